@@ hdl/sparse_sor_solver_defines.svh @@
// ----------------------------------------------------------------------------
// sparse_sor_solver_defines.svh
// assertion macros shared by the solver rtl
// ----------------------------------------------------------------------------
`ifndef SPARSE_SOR_SOLVER_DEFINES_SVH
`define SPARSE_SOR_SOLVER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// shared constants and types of the sparse sor solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sss_pkg;

    localparam int MAX_DIM_DEFAULT     = 64;
    localparam int MAX_ENTRIES_DEFAULT = 512;

    localparam int ROW_W   = 6;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;

    // input actions
    localparam logic [1:0] ACT_MATRIX = 2'd0;
    localparam logic [1:0] ACT_RHS    = 2'd1;
    localparam logic [1:0] ACT_START  = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_DIM       = 3'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_ITER  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TOLERANCE = 3'd2;
    localparam logic [CIDX_W-1:0] REG_RELAX     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_THRESHOLD = 3'd4;

    // register reset values
    localparam logic [6:0]  DIM_RESET       = 7'd64;
    localparam logic [15:0] MAX_ITER_RESET  = 16'd100;
    localparam logic [30:0] TOLERANCE_RESET = 31'd66;
    localparam logic [17:0] RELAX_RESET     = 18'd65536;
    localparam logic signed [31:0] THRESHOLD_RESET = 32'sh7FFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ROW_RD,
        ST_ROW_SETUP,
        ST_ENT_RD,
        ST_ENT_COL,
        ST_ENT_MUL,
        ST_ENT_ACC,
        ST_ROW_CALC,
        ST_DIV,
        ST_DIV_FIX,
        ST_REL_M1,
        ST_REL_M2,
        ST_REL_SUM,
        ST_ROW_CHECK,
        ST_SWEEP_END,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } sss_state_t;

endpackage

@@ hdl/sss_if.sv @@
// ----------------------------------------------------------------------------
// sss_if
// valid/ready channels for input items and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sss_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  row;
    logic [5:0]  column;
    logic signed [31:0] value;

    modport source (output valid, output action, output row, output column,
                    output value, input ready);
    modport sink   (input valid, input action, input row, input column,
                    input value, output ready);
endinterface

interface sss_result_if;
    logic        valid;
    logic        ready;
    logic [5:0]  index;
    logic signed [31:0] component;
    logic        converged;
    logic        zero_diagonal;
    logic        last;

    modport source (output valid, output index, output component, output converged,
                    output zero_diagonal, output last, input ready);
    modport sink   (input valid, input index, input component, input converged,
                    input zero_diagonal, input last, output ready);
endinterface

@@ hdl/sparse_sor_solver.sv @@
// ----------------------------------------------------------------------------
// sparse_sor_solver
// sor / gauss-seidel solver over a row-compressed matrix, q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel   dir  handshake     contents
//  items     in   valid/ready   action, row, column, value
//  results   out  valid/ready   index, component, converged, zero_diagonal, last
//  cfg       in   cfg_we        cfg_index, cfg_data
//
//  async active-low reset; load words are taken back to back; ready is high only while idle
//  solve: per row row_rd, row_setup, row_calc and row_check; per entry ent_rd and
//  ent_col, plus ent_mul and ent_acc if off-diagonal; a nonzero diagonal adds the
//  64-step divider loop, div_fix and the relax steps; each sweep adds sweep and sweep_end
//  each result word passes out_rd, out_load and out_wait; valid bits replace any clearing pass
//  a result stall holds the block; the next item is taken after the last word
`timescale 1ns / 1ps

`include "sparse_sor_solver_defines.svh"

module sparse_sor_solver #(
    parameter int MAX_DIM     = sss_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_ENTRIES = sss_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sss_item_if.sink                     items,
    sss_result_if.source                 results,
    input  logic                         cfg_we,
    input  logic [sss_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [sss_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IW = $clog2(MAX_DIM);          // row / column address
    localparam int DW = $clog2(MAX_DIM + 1);      // dimension count
    localparam int AW = $clog2(MAX_ENTRIES);      // entry address
    localparam int CW = $clog2(MAX_ENTRIES + 1);  // entry count

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0]         dim_cfg_reg;
    logic [15:0]        maxit_cfg_reg;
    logic [30:0]        tol_cfg_reg;
    logic [17:0]        w_cfg_reg;
    logic signed [31:0] thr_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cfg_reg   <= sss_pkg::DIM_RESET;
            maxit_cfg_reg <= sss_pkg::MAX_ITER_RESET;
            tol_cfg_reg   <= sss_pkg::TOLERANCE_RESET;
            w_cfg_reg     <= sss_pkg::RELAX_RESET;
            thr_cfg_reg   <= sss_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sss_pkg::REG_DIM:       dim_cfg_reg   <= cfg_data[6:0];
                sss_pkg::REG_MAX_ITER:  maxit_cfg_reg <= cfg_data[15:0];
                sss_pkg::REG_TOLERANCE: tol_cfg_reg   <= cfg_data[30:0];
                sss_pkg::REG_RELAX:     w_cfg_reg     <= cfg_data[17:0];
                sss_pkg::REG_THRESHOLD: thr_cfg_reg   <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories
    //   ent_mem : packed entries {column, value}
    //   lc_mem  : per row, entry count after the latest entry of that row;
    //             row start = running max over earlier rows
    //   rhs_mem : right-hand side
    //   sol_mem : solution, gated by sol_valid (cleared at each solve)
    // ------------------------------------------------------------------
    logic [IW+31:0]     ent_mem [MAX_ENTRIES];
    logic [CW-1:0]      lc_mem  [MAX_DIM];
    logic signed [31:0] rhs_mem [MAX_DIM];
    logic signed [31:0] sol_mem [MAX_DIM];

    logic               ent_we, ent_re;
    logic [AW-1:0]      ent_wa, ent_ra;
    logic [IW+31:0]     ent_wd, ent_rd;

    logic               lc_we, lc_re;
    logic [IW-1:0]      lc_wa, lc_ra;
    logic [CW-1:0]      lc_wd, lc_rd;
    logic               lc_rd_ok;

    logic               rhs_we, rhs_re;
    logic [IW-1:0]      rhs_wa, rhs_ra;
    logic signed [31:0] rhs_wd, rhs_rd;

    logic               sol_we, sol_re;
    logic [IW-1:0]      sol_wa, sol_ra;
    logic signed [31:0] sol_wd, sol_rd;
    logic               sol_rd_ok;

    logic [MAX_DIM-1:0] lc_valid_reg, lc_valid_next;
    logic [MAX_DIM-1:0] sol_valid_reg, sol_valid_next;

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wa] <= ent_wd;
        if (ent_re)
            ent_rd <= ent_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lc_we)
            lc_mem[lc_wa] <= lc_wd;
        if (lc_re)
        begin
            lc_rd    <= lc_mem[lc_ra];
            lc_rd_ok <= lc_valid_reg[lc_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rhs_we)
            rhs_mem[rhs_wa] <= rhs_wd;
        if (rhs_re)
            rhs_rd <= rhs_mem[rhs_ra];
    end

    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_wa] <= sol_wd;
        if (sol_re)
        begin
            sol_rd    <= sol_mem[sol_ra];
            sol_rd_ok <= sol_valid_reg[sol_ra];
        end
    end

    // ------------------------------------------------------------------
    // solver registers
    // ------------------------------------------------------------------
    sss_pkg::sss_state_t state_reg, state_next;

    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]      dim_reg, dim_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [15:0]        it_reg, it_next;
    logic [32:0]        maxdiff_reg, maxdiff_next;
    logic [CW-1:0]      runmax_reg, runmax_next;
    logic [CW-1:0]      end_reg, end_next;
    logic [CW-1:0]      k_reg, k_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [31:0] diag_reg, diag_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        num_reg, num_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        den_reg, den_next;
    logic               qneg_reg, qneg_next;
    logic [5:0]         divcnt_reg, divcnt_next;
    logic signed [31:0] nx_reg, nx_next;
    logic signed [31:0] rel_reg, rel_next;
    logic               zdiag_reg, zdiag_next;
    logic               conv_reg, conv_next;
    logic [IW-1:0]      o_reg, o_next;

    logic [5:0]         out_index_reg, out_index_next;
    logic signed [31:0] out_comp_reg, out_comp_next;
    logic               out_last_reg, out_last_next;

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;

    // combinational helpers
    logic               accept;
    logic [CW-1:0]      k_inc;
    logic [CW-1:0]      lc_eff;
    logic signed [63:0] b_wide;
    logic signed [64:0] res_full;
    logic signed [63:0] res;
    logic signed [64:0] acc_full;
    logic signed [64:0] sum_round;
    logic signed [47:0] rel_shift;
    logic signed [31:0] rel_sat;
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic [32:0]        div_shift;
    logic [16:0]        it_inc;
    logic [DW-1:0]      dim_clamp;
    logic [IW:0]        i_plus;
    logic [IW:0]        o_plus;

    assign accept        = items.valid && items.ready;
    assign items.ready   = (state_reg == sss_pkg::ST_IDLE);
    assign results.valid = (state_reg == sss_pkg::ST_OUT_WAIT);
    assign results.index         = out_index_reg;
    assign results.component     = out_comp_reg;
    assign results.converged     = conv_reg;
    assign results.zero_diagonal = zdiag_reg;
    assign results.last          = out_last_reg;

    assign k_inc     = k_reg + CW'(1);
    assign lc_eff    = lc_rd_ok ? lc_rd : '0;
    assign b_wide    = {{16{b_reg[31]}}, b_reg, 16'd0};
    assign res_full  = {b_wide[63], b_wide} - {sum_reg[63], sum_reg};
    assign acc_full  = {sum_reg[63], sum_reg} + {prod_reg[63], prod_reg};
    assign sum_round = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg} + 65'sd32768;
    assign rel_shift = 48'(sum_round >>> 16);
    assign diff      = {rel_sat[31], rel_sat} - {x_reg[31], x_reg};
    assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
    assign div_shift = {rem_reg[31:0], num_reg[63]};
    assign it_inc    = {1'b0, it_reg} + 17'd1;
    assign i_plus    = {1'b0, i_reg} + (IW+1)'(1);
    assign o_plus    = {1'b0, o_reg} + (IW+1)'(1);

    // saturate the residual to the 64-bit range
    always_comb
    begin
        if (res_full > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            res = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (res_full < -65'sh0_8000_0000_0000_0000)
            res = 64'sh8000_0000_0000_0000;
        else
            res = 64'(res_full);
    end

    always_comb
    begin
        if (rel_shift > 48'sh7FFF_FFFF)
            rel_sat = 32'sh7FFF_FFFF;
        else if (rel_shift < -48'sh8000_0000)
            rel_sat = 32'sh8000_0000;
        else
            rel_sat = 32'(rel_shift);
    end

    // dimension 0 acts as 1, above the store as the store size
    always_comb
    begin
        if (dim_cfg_reg == 7'd0)
            dim_clamp = DW'(1);
        else if (32'(dim_cfg_reg) > MAX_DIM)
            dim_clamp = DW'(MAX_DIM);
        else
            dim_clamp = DW'(dim_cfg_reg);
    end

    // ------------------------------------------------------------------
    // state register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sss_pkg::ST_IDLE;
            cnt_reg       <= '0;
            lc_valid_reg  <= '0;
            sol_valid_reg <= '0;
            zdiag_reg     <= 1'b0;
            conv_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lc_valid_reg  <= lc_valid_next;
            sol_valid_reg <= sol_valid_next;
            zdiag_reg     <= zdiag_next;
            conv_reg      <= conv_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        dim_reg       <= dim_next;
        i_reg         <= i_next;
        it_reg        <= it_next;
        maxdiff_reg   <= maxdiff_next;
        runmax_reg    <= runmax_next;
        end_reg       <= end_next;
        k_reg         <= k_next;
        x_reg         <= x_next;
        b_reg         <= b_next;
        sum_reg       <= sum_next;
        diag_reg      <= diag_next;
        val_reg       <= val_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        qneg_reg      <= qneg_next;
        divcnt_reg    <= divcnt_next;
        nx_reg        <= nx_next;
        rel_reg       <= rel_next;
        o_reg         <= o_next;
        out_index_reg <= out_index_next;
        out_comp_reg  <= out_comp_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lc_valid_next  = lc_valid_reg;
        sol_valid_next = sol_valid_reg;
        zdiag_next     = zdiag_reg;
        conv_next      = conv_reg;
        dim_next       = dim_reg;
        i_next         = i_reg;
        it_next        = it_reg;
        maxdiff_next   = maxdiff_reg;
        runmax_next    = runmax_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        x_next         = x_reg;
        b_next         = b_reg;
        sum_next       = sum_reg;
        diag_next      = diag_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        qneg_next      = qneg_reg;
        divcnt_next    = divcnt_reg;
        nx_next        = nx_reg;
        rel_next       = rel_reg;
        o_next         = o_reg;
        out_index_next = out_index_reg;
        out_comp_next  = out_comp_reg;
        out_last_next  = out_last_reg;

        mul_a = val_reg;
        mul_b = sol_rd;

        ent_we = 1'b0;
        ent_wa = cnt_reg[AW-1:0];
        ent_wd = {items.column[IW-1:0], items.value};
        ent_re = 1'b0;
        ent_ra = k_reg[AW-1:0];
        lc_we  = 1'b0;
        lc_wa  = items.row[IW-1:0];
        lc_wd  = cnt_reg + CW'(1);
        lc_re  = 1'b0;
        lc_ra  = i_reg;
        rhs_we = 1'b0;
        rhs_wa = items.row[IW-1:0];
        rhs_wd = items.value;
        rhs_re = 1'b0;
        rhs_ra = i_reg;
        sol_we = 1'b0;
        sol_wa = i_reg;
        sol_wd = rel_sat;
        sol_re = 1'b0;
        sol_ra = i_reg;

        case (state_reg)
            sss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (items.action)
                        sss_pkg::ACT_MATRIX:
                        begin
                            if (32'(items.row) < MAX_DIM && 32'(items.column) < MAX_DIM
                                && cnt_reg < CW'(MAX_ENTRIES))
                            begin
                                ent_we = 1'b1;
                                lc_we  = 1'b1;
                                lc_valid_next[items.row[IW-1:0]] = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        sss_pkg::ACT_RHS:
                        begin
                            if (32'(items.row) < MAX_DIM)
                                rhs_we = 1'b1;
                        end
                        sss_pkg::ACT_START:
                        begin
                            dim_next       = dim_clamp;
                            sol_valid_next = '0;
                            zdiag_next     = 1'b0;
                            conv_next      = 1'b0;
                            it_next        = '0;
                            o_next         = '0;
                            if (maxit_cfg_reg == 16'd0)
                                state_next = sss_pkg::ST_OUT_RD;
                            else
                                state_next = sss_pkg::ST_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end

            sss_pkg::ST_SWEEP:
            begin
                i_next       = '0;
                maxdiff_next = '0;
                runmax_next  = '0;
                state_next   = sss_pkg::ST_ROW_RD;
            end

            sss_pkg::ST_ROW_RD:
            begin
                lc_re      = 1'b1;
                rhs_re     = 1'b1;
                sol_re     = 1'b1;
                state_next = sss_pkg::ST_ROW_SETUP;
            end

            sss_pkg::ST_ROW_SETUP:
            begin
                // row end not above start means empty row
                x_next    = sol_rd_ok ? sol_rd : 32'sd0;
                b_next    = rhs_rd;
                sum_next  = '0;
                diag_next = '0;
                k_next    = runmax_reg;
                if (lc_eff > runmax_reg)
                begin
                    end_next    = lc_eff;
                    runmax_next = lc_eff;
                    state_next  = sss_pkg::ST_ENT_RD;
                end
                else
                begin
                    end_next   = runmax_reg;
                    state_next = sss_pkg::ST_ROW_CALC;
                end
            end

            sss_pkg::ST_ENT_RD:
            begin
                ent_re     = 1'b1;
                state_next = sss_pkg::ST_ENT_COL;
            end

            sss_pkg::ST_ENT_COL:
            begin
                if (ent_rd[IW+31:32] == i_reg)
                begin
                    // diagonal entry, the last one of the row counts
                    diag_next  = $signed(ent_rd[31:0]);
                    k_next     = k_inc;
                    state_next = (k_inc < end_reg) ? sss_pkg::ST_ENT_RD
                                                   : sss_pkg::ST_ROW_CALC;
                end
                else
                begin
                    val_next   = $signed(ent_rd[31:0]);
                    sol_re     = 1'b1;
                    sol_ra     = ent_rd[IW+31:32];
                    state_next = sss_pkg::ST_ENT_MUL;
                end
            end

            sss_pkg::ST_ENT_MUL:
            begin
                mul_a      = val_reg;
                mul_b      = sol_rd_ok ? sol_rd : 32'sd0;
                prod_next  = mul_a * mul_b;
                state_next = sss_pkg::ST_ENT_ACC;
            end

            sss_pkg::ST_ENT_ACC:
            begin
                if (acc_full > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                    sum_next = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (acc_full < -65'sh0_8000_0000_0000_0000)
                    sum_next = 64'sh8000_0000_0000_0000;
                else
                    sum_next = 64'(acc_full);
                k_next     = k_inc;
                state_next = (k_inc < end_reg) ? sss_pkg::ST_ENT_RD
                                               : sss_pkg::ST_ROW_CALC;
            end

            sss_pkg::ST_ROW_CALC:
            begin
                if (diag_reg == 32'sd0)
                begin
                    // component keeps its value, change zero
                    zdiag_next = 1'b1;
                    rel_next   = x_reg;
                    state_next = sss_pkg::ST_ROW_CHECK;
                end
                else
                begin
                    num_next    = res[63] ? 64'(-res) : 64'(res);
                    den_next    = diag_reg[31] ? 32'(-diag_reg) : 32'(diag_reg);
                    qneg_next   = res[63] ^ diag_reg[31];
                    rem_next    = '0;
                    divcnt_next = '0;
                    state_next  = sss_pkg::ST_DIV;
                end
            end

            sss_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (div_shift >= {1'b0, den_reg})
                begin
                    rem_next = div_shift - {1'b0, den_reg};
                    num_next = {num_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift;
                    num_next = {num_reg[62:0], 1'b0};
                end
                divcnt_next = divcnt_reg + 6'd1;
                if (divcnt_reg == 6'd63)
                    state_next = sss_pkg::ST_DIV_FIX;
            end

            sss_pkg::ST_DIV_FIX:
            begin
                if (!qneg_reg)
                    nx_next = (num_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                        : $signed(num_reg[31:0]);
                else
                    nx_next = (num_reg > 64'h8000_0000) ? 32'sh8000_0000
                                                        : $signed(32'(-num_reg));
                state_next = sss_pkg::ST_REL_M1;
            end

            sss_pkg::ST_REL_M1:
            begin
                // (1 - w) * x
                mul_a      = 32'sd65536 - $signed({14'd0, w_cfg_reg});
                mul_b      = x_reg;
                prod_next  = mul_a * mul_b;
                state_next = sss_pkg::ST_REL_M2;
            end

            sss_pkg::ST_REL_M2:
            begin
                // w * new x
                acc_next   = prod_reg;
                mul_a      = $signed({14'd0, w_cfg_reg});
                mul_b      = nx_reg;
                prod_next  = mul_a * mul_b;
                state_next = sss_pkg::ST_REL_SUM;
            end

            sss_pkg::ST_REL_SUM:
            begin
                sol_we = 1'b1;
                sol_valid_next[i_reg] = 1'b1;
                rel_next = rel_sat;
                if (diff_abs > maxdiff_reg)
                    maxdiff_next = diff_abs;
                state_next = sss_pkg::ST_ROW_CHECK;
            end

            sss_pkg::ST_ROW_CHECK:
            begin
                if (rel_reg >= thr_cfg_reg || DW'(i_plus) == dim_reg)
                    state_next = sss_pkg::ST_SWEEP_END;
                else
                begin
                    i_next     = i_plus[IW-1:0];
                    state_next = sss_pkg::ST_ROW_RD;
                end
            end

            sss_pkg::ST_SWEEP_END:
            begin
                it_next = it_inc[15:0];
                if (maxdiff_reg < {2'b00, tol_cfg_reg})
                begin
                    conv_next  = 1'b1;
                    state_next = sss_pkg::ST_OUT_RD;
                end
                else if (it_inc >= {1'b0, maxit_cfg_reg})
                    state_next = sss_pkg::ST_OUT_RD;
                else
                    state_next = sss_pkg::ST_SWEEP;
            end

            sss_pkg::ST_OUT_RD:
            begin
                sol_re     = 1'b1;
                sol_ra     = o_reg;
                state_next = sss_pkg::ST_OUT_LOAD;
            end

            sss_pkg::ST_OUT_LOAD:
            begin
                out_index_next = 6'(o_reg);
                out_comp_next  = sol_rd_ok ? sol_rd : 32'sd0;
                out_last_next  = (DW'(o_plus) == dim_reg);
                state_next     = sss_pkg::ST_OUT_WAIT;
            end

            sss_pkg::ST_OUT_WAIT:
            begin
                if (results.ready)
                begin
                    if (out_last_reg)
                    begin
                        // next matrix loads from empty
                        cnt_next      = '0;
                        lc_valid_next = '0;
                        state_next    = sss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        o_next     = o_plus[IW-1:0];
                        state_next = sss_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
                state_next = sss_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SSS_ASSERT_NOW(a_no_overlap, items.ready, !results.valid, "input taken while result pending")
    `SSS_ASSERT_NOW(a_sol_we_diag, sol_we, diag_reg != 32'sd0, "solution write on zero diagonal")
    `SSS_ASSERT_NOW(a_last_index, results.valid && results.last, DW'(results.index) + DW'(1) == dim_reg, "last flag off the final index")
    `SSS_ASSERT_NEXT(a_div_entry, state_reg == sss_pkg::ST_ROW_CALC && diag_reg != 32'sd0, state_reg == sss_pkg::ST_DIV, "divider not started")

endmodule
